// ===== src/tt_pkg.sv =====
// tt_pkg: shared types, constants and score helpers for the transposition table
// depends on nothing; used by every module of the block except tt_checker
`default_nettype none

package tt_pkg;

    localparam logic MODE_PROBE = 1'b0;
    localparam logic MODE_STORE = 1'b1;

    localparam int MATE_VALUE  = 32000;
    localparam int MATE_WINDOW = 512;
    localparam logic signed [15:0] MATE_LIMIT = 16'(MATE_VALUE - MATE_WINDOW);
    localparam logic signed [17:0] SCORE_MAX  = 18'sd32767;

    // one queued word, already classified and with its score prepared
    typedef struct packed {
        logic               mode;
        logic [63:0]        key;
        logic [7:0]         ply;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [15:0]        move;
        logic [1:0]         bound;
    } tt_item_t;

    // one table entry
    typedef struct packed {
        logic               occupied;
        logic [63:0]        tag;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [15:0]        move;
        logic [1:0]         bound;
        logic [7:0]         age;
    } tt_entry_t;

    // result word
    typedef struct packed {
        logic               hit;
        logic [7:0]         depth;
        logic signed [15:0] score;
        logic [15:0]        move;
        logic [1:0]         bound;
        logic               stored;
    } tt_result_t;

    // queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } tt_q_status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } tt_back_state_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > SCORE_MAX) begin
            r = 16'(SCORE_MAX);
        end else if (v < -SCORE_MAX) begin
            r = 16'(-SCORE_MAX);
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // mate scores move away from the root on the way into the table
    function automatic logic signed [15:0] score_to_table(input logic signed [15:0] s,
                                                           input logic [7:0] ply);
        logic signed [17:0] sx;
        logic signed [17:0] px;
        logic signed [15:0] r;
        sx = {{2{s[15]}}, s};
        px = {10'b0, ply};
        if (s > MATE_LIMIT) begin
            r = sat16(sx + px);
        end else if (s < -MATE_LIMIT) begin
            r = sat16(sx - px);
        end else begin
            r = s;
        end
        return r;
    endfunction

    // and back toward the root on the way out
    function automatic logic signed [15:0] score_from_table(input logic signed [15:0] s,
                                                             input logic [7:0] ply);
        logic signed [17:0] sx;
        logic signed [17:0] px;
        logic signed [15:0] r;
        sx = {{2{s[15]}}, s};
        px = {10'b0, ply};
        if (s > MATE_LIMIT) begin
            r = sat16(sx - px);
        end else if (s < -MATE_LIMIT) begin
            r = sat16(sx + px);
        end else begin
            r = sat16(sx);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/transposition_table_top.sv =====
// transposition_table_top: direct-mapped position hash table with depth-preferred replacement
// depends on tt_pkg, tt_front, tt_queue, tt_back
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      mode, key, ply, depth, score, move, bound
//  m_        out        m_valid / m_ready      hit, hit depth/score/move/bound, stored
//  cfg_      in         cfg_valid / cfg_ready  search generation (8 bits)
//
// each word passes through two back-end steps: the registered table read, then
// the compare, optional write-back and result load
// the front end and a two-word queue keep taking words while the back end works
// after reset the back end walks the table to mark every entry empty; s_ready
// stays low until that pass ends, cfg writes are taken throughout
// a stalled result holds the back end in its execute step; the queue absorbs two more words
`default_nettype none

module transposition_table_top #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_search_generation,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic [63:0]        s_lookup_key,
    input  wire logic [7:0]         s_ply,
    input  wire logic [7:0]         s_search_depth,
    input  wire logic signed [15:0] s_score_in,
    input  wire logic [15:0]        s_move_word,
    input  wire logic [1:0]         s_bound_kind,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic [7:0]              m_hit_depth,
    output logic signed [15:0]      m_hit_score,
    output logic [15:0]             m_hit_move,
    output logic [1:0]              m_hit_bound,
    output logic                    m_stored
);

    // search generation register, stamped into stored entries
    logic [7:0] gen_reg, gen_next;

    tt_pkg::tt_q_status_t q_status;
    tt_pkg::tt_item_t     push_item;
    tt_pkg::tt_item_t     q_head;
    tt_pkg::tt_result_t   result;
    logic                 q_push;
    logic                 q_pop;
    logic                 clear_busy;

    assign cfg_ready = 1'b1;
    assign gen_next  = (cfg_valid && cfg_ready) ? cfg_search_generation : gen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= 8'd0;
        end else begin
            gen_reg <= gen_next;
        end
    end

    // front: accept and prepare
    tt_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_lookup_key   (s_lookup_key),
        .s_ply          (s_ply),
        .s_search_depth (s_search_depth),
        .s_score_in     (s_score_in),
        .s_move_word    (s_move_word),
        .s_bound_kind   (s_bound_kind),
        .q_status       (q_status),
        .clear_busy     (clear_busy),
        .q_push         (q_push),
        .q_item         (push_item)
    );

    // decoupling queue
    tt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    // back: table access and result register
    tt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .search_generation (gen_reg),
        .q_head            (q_head),
        .q_status          (q_status),
        .q_pop             (q_pop),
        .clear_busy        (clear_busy),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .result            (result)
    );

    assign m_hit       = result.hit;
    assign m_hit_depth = result.depth;
    assign m_hit_score = result.score;
    assign m_hit_move  = result.move;
    assign m_hit_bound = result.bound;
    assign m_stored    = result.stored;

endmodule

`default_nettype wire

// ===== src/tt_front.sv =====
// tt_front: accepts input words, classifies them and prepares store scores
// depends on tt_pkg
`default_nettype none

module tt_front (
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [63:0]          s_lookup_key,
    input  wire logic [7:0]           s_ply,
    input  wire logic [7:0]           s_search_depth,
    input  wire logic signed [15:0]   s_score_in,
    input  wire logic [15:0]          s_move_word,
    input  wire logic [1:0]           s_bound_kind,
    input  wire tt_pkg::tt_q_status_t q_status,
    input  wire logic                 clear_busy,
    output logic                      q_push,
    output tt_pkg::tt_item_t          q_item
);

    assign s_ready = !q_status.full && !clear_busy;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_item       = '0;
        q_item.mode  = s_mode;
        q_item.key   = s_lookup_key;
        q_item.ply   = s_ply;
        if (s_mode == tt_pkg::MODE_STORE) begin
            // only stores carry payload into the table
            q_item.depth = s_search_depth;
            q_item.score = tt_pkg::score_to_table(s_score_in, s_ply);
            q_item.move  = s_move_word;
            q_item.bound = s_bound_kind;
        end
    end

endmodule

`default_nettype wire

// ===== src/tt_queue.sv =====
// tt_queue: two-word queue between front and back
// depends on tt_pkg
`default_nettype none

module tt_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire tt_pkg::tt_item_t     push_item,
    input  wire logic                 pop,
    output tt_pkg::tt_item_t          head,
    output tt_pkg::tt_q_status_t      status
);

    tt_pkg::tt_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign head         = slot_reg[rd_ptr_reg];
    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/tt_back.sv =====
// tt_back: table memory, clearing pass, probe and store execution, result register
// depends on tt_pkg
`default_nettype none

module tt_back #(
    parameter int unsigned TABLE_ENTRIES = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [7:0]           search_generation,
    input  wire tt_pkg::tt_item_t     q_head,
    input  wire tt_pkg::tt_q_status_t q_status,
    output logic                      q_pop,
    output logic                      clear_busy,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output tt_pkg::tt_result_t        result
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    tt_pkg::tt_entry_t mem [TABLE_ENTRIES];

    tt_pkg::tt_back_state_t state_reg, state_next;
    logic [IDX_W-1:0]       clr_cnt_reg, clr_cnt_next;
    tt_pkg::tt_item_t       item_reg;
    tt_pkg::tt_entry_t      rd_data_reg;
    logic                   out_valid_reg, out_valid_next;
    tt_pkg::tt_result_t     out_reg;

    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    tt_pkg::tt_entry_t      wr_data;
    logic                   out_load;
    tt_pkg::tt_result_t     res_next;
    logic                   out_free;
    logic                   tag_hit;
    logic                   replace;

    assign clear_busy = (state_reg == tt_pkg::BK_CLEAR);
    assign out_free   = !out_valid_reg || m_ready;
    assign tag_hit    = rd_data_reg.occupied && (rd_data_reg.tag == item_reg.key);
    assign replace    = !rd_data_reg.occupied || (rd_data_reg.depth <= item_reg.depth) ||
                        (rd_data_reg.age != search_generation);

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        q_pop        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = clr_cnt_reg;
        wr_data      = '0;
        out_load     = 1'b0;
        res_next     = '0;
        case (state_reg)
            tt_pkg::BK_CLEAR: begin
                // occupied bit of each entry dropped, one entry a cycle
                wr_en = 1'b1;
                if (clr_cnt_reg == LAST_IDX) begin
                    state_next = tt_pkg::BK_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            tt_pkg::BK_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    state_next = tt_pkg::BK_EXEC;
                end
            end
            tt_pkg::BK_EXEC: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = tt_pkg::BK_IDLE;
                    if (item_reg.mode == tt_pkg::MODE_STORE) begin
                        res_next.stored = replace;
                        if (replace) begin
                            wr_en            = 1'b1;
                            wr_addr          = item_reg.key[IDX_W-1:0];
                            wr_data.occupied = 1'b1;
                            wr_data.tag      = item_reg.key;
                            wr_data.depth    = item_reg.depth;
                            wr_data.score    = item_reg.score;
                            wr_data.move     = item_reg.move;
                            wr_data.bound    = item_reg.bound;
                            wr_data.age      = search_generation;
                        end
                    end else if (tag_hit) begin
                        res_next.hit   = 1'b1;
                        res_next.depth = rd_data_reg.depth;
                        res_next.score = tt_pkg::score_from_table(rd_data_reg.score,
                                                                  item_reg.ply);
                        res_next.move  = rd_data_reg.move;
                        res_next.bound = rd_data_reg.bound;
                    end
                end
            end
            default: begin
                state_next = tt_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tt_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_data_reg <= mem[q_head.key[IDX_W-1:0]];
            item_reg    <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = out_reg;

endmodule

`default_nettype wire

// ===== src/tt_checker.sv =====
// tt_checker: port-level assertions for the transposition table, bound to the top level
// depends on transposition_table_top port names
`default_nettype none

module tt_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_hit,
    input wire logic [7:0]         m_hit_depth,
    input wire logic signed [15:0] m_hit_score,
    input wire logic [15:0]        m_hit_move,
    input wire logic [1:0]         m_hit_bound,
    input wire logic               m_stored
);

    // reset empties the result register and starts the clearing pass
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("result or input ready visible right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_stored) &&
                                $stable(m_hit_score) && $stable(m_hit_depth))
        else $error("stalled result changed");

    // a word is a probe hit or a replacing store, never both
    a_hit_xor_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_stored))
        else $error("hit and stored both set");

    // misses and stores carry zero hit fields
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_hit_depth == 8'd0 && m_hit_score == 16'sd0 &&
                              m_hit_move == 16'd0 && m_hit_bound == 2'd0)
        else $error("hit fields set without a hit");

    // returned scores stay inside the saturated range
    a_score_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_hit_score != 16'sh8000)
        else $error("hit score out of range");

endmodule

bind transposition_table_top tt_checker u_tt_checker (.*);

`default_nettype wire

// ===== tb/transposition_table_top_tb.sv =====
`timescale 1ns / 1ps
// transposition_table_top_tb: self-checking bench for the position hash table, with
// directed, replacement and random probe/store traffic checked against a shadow table
// depends on tt_pkg and transposition_table_top

module transposition_table_top_tb;

    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
    localparam int SCORE_CEIL    = 32767;
    localparam int MATE_EDGE     = tt_pkg::MATE_VALUE - tt_pkg::MATE_WINDOW;
    localparam int SCORE_SPAN    = 32000;
    localparam int CLK_HALF      = 6;
    // clearing pass after reset dominates the longest quiet stretch
    localparam int STALL_LIMIT   = 4 * TABLE_ENTRIES + 2000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int POOL_SLOTS    = 8;
    localparam int POOL_SIZE     = 32;
    localparam int RANDOM_BLOCKS = 4;
    localparam int BLOCK_WORDS   = 132;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #(CLK_HALF) aclk = ~aclk;

    // block ports, every input known from time zero
    logic               cfg_valid             = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_search_generation = '0;
    logic               s_valid               = 1'b0;
    logic               s_ready;
    logic               s_mode                = tt_pkg::MODE_PROBE;
    logic [63:0]        s_lookup_key          = '0;
    logic [7:0]         s_ply                 = '0;
    logic [7:0]         s_search_depth        = '0;
    logic signed [15:0] s_score_in            = '0;
    logic [15:0]        s_move_word           = '0;
    logic [1:0]         s_bound_kind          = '0;
    logic               m_valid;
    logic               m_ready               = 1'b0;
    logic               m_hit;
    logic [7:0]         m_hit_depth;
    logic signed [15:0] m_hit_score;
    logic [15:0]        m_hit_move;
    logic [1:0]         m_hit_bound;
    logic               m_stored;

    transposition_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_search_generation(cfg_search_generation),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_mode               (s_mode),
        .s_lookup_key         (s_lookup_key),
        .s_ply                (s_ply),
        .s_search_depth       (s_search_depth),
        .s_score_in           (s_score_in),
        .s_move_word          (s_move_word),
        .s_bound_kind         (s_bound_kind),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_hit                (m_hit),
        .m_hit_depth          (m_hit_depth),
        .m_hit_score          (m_hit_score),
        .m_hit_move           (m_hit_move),
        .m_hit_bound          (m_hit_bound),
        .m_stored             (m_stored)
    );

    // shadow copy of the table and the generation register
    tt_pkg::tt_entry_t  shadow_table [TABLE_ENTRIES];
    logic [7:0]         shadow_generation;

    // results still owed by the block, oldest first
    tt_pkg::tt_result_t pending_results [$];
    tt_pkg::tt_result_t expected_word;

    // random traffic keys, clustered on a few slots so probes hit and stores collide
    logic [63:0] key_pool [POOL_SIZE];

    // when set, neither side inserts idle cycles
    bit no_idle = 1'b0;

    int failures    = 0;
    int idle_cycles = 0;
    int n_probes    = 0;
    int n_hits      = 0;
    int n_stores    = 0;
    int n_writes    = 0;
    int n_settings  = 0;

    // mate scores drift by ply: away from the root going in, back toward it coming out
    function automatic logic signed [15:0] rebase_mate_score(input int score, input int ply,
                                                             input bit into_table);
        int v;
        v = score;
        if (score > MATE_EDGE) begin
            v = into_table ? score + ply : score - ply;
        end else if (score < -MATE_EDGE) begin
            v = into_table ? score - ply : score + ply;
        end
        if (v > SCORE_CEIL) begin
            v = SCORE_CEIL;
        end else if (v < -SCORE_CEIL) begin
            v = -SCORE_CEIL;
        end
        return 16'(v);
    endfunction

    // applies one probe or store word to the shadow table and returns the result it owes
    function automatic tt_pkg::tt_result_t predict_table_access(input tt_pkg::tt_item_t w);
        tt_pkg::tt_result_t r;
        int                 slot;
        r    = '0;
        slot = int'(w.key[SLOT_BITS-1:0]);
        if (w.mode == tt_pkg::MODE_PROBE) begin
            if (shadow_table[slot].occupied && shadow_table[slot].tag == w.key) begin
                r.hit   = 1'b1;
                r.depth = shadow_table[slot].depth;
                r.score = rebase_mate_score(int'(shadow_table[slot].score), int'(w.ply), 1'b0);
                r.move  = shadow_table[slot].move;
                r.bound = shadow_table[slot].bound;
            end
        end else begin
            // depth-preferred, but stale generations always lose
            if (!shadow_table[slot].occupied || shadow_table[slot].depth <= w.depth ||
                shadow_table[slot].age != shadow_generation) begin
                shadow_table[slot].occupied = 1'b1;
                shadow_table[slot].tag      = w.key;
                shadow_table[slot].depth    = w.depth;
                shadow_table[slot].score    = rebase_mate_score(int'(w.score), int'(w.ply), 1'b1);
                shadow_table[slot].move     = w.move;
                shadow_table[slot].bound    = w.bound;
                shadow_table[slot].age      = shadow_generation;
                r.stored = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic tt_pkg::tt_item_t make_word(input logic mode, input logic [63:0] key,
                                                   input logic [7:0] ply,
                                                   input logic [7:0] depth,
                                                   input int score, input logic [15:0] move,
                                                   input logic [1:0] bound);
        tt_pkg::tt_item_t w;
        w.mode  = mode;
        w.key   = key;
        w.ply   = ply;
        w.depth = depth;
        w.score = 16'(score);
        w.move  = move;
        w.bound = bound;
        return w;
    endfunction

    // mostly pool keys with random content, some keys that land anywhere
    function automatic tt_pkg::tt_item_t random_word();
        tt_pkg::tt_item_t w;
        w.mode = ($urandom_range(0, 1) == 1) ? tt_pkg::MODE_STORE : tt_pkg::MODE_PROBE;
        if ($urandom_range(0, 99) < 85) begin
            w.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else begin
            w.key = {$urandom, $urandom};
        end
        w.ply = 8'($urandom_range(0, 255));
        // shallow depths keep the replacement compare busy, a quarter span the full range
        if ($urandom_range(0, 3) == 0) begin
            w.depth = 8'($urandom_range(0, 255));
        end else begin
            w.depth = 8'($urandom_range(0, 12));
        end
        case ($urandom_range(0, 2))
            0: begin
                w.score = 16'(int'($urandom_range(MATE_EDGE - 90, SCORE_SPAN)));
            end
            1: begin
                w.score = 16'(-int'($urandom_range(MATE_EDGE - 90, SCORE_SPAN)));
            end
            default: begin
                w.score = 16'(int'($urandom_range(0, 2 * SCORE_SPAN)) - SCORE_SPAN);
            end
        endcase
        w.move  = 16'($urandom);
        w.bound = 2'($urandom_range(0, 2));
        return w;
    endfunction

    function automatic void check_field(input string field, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    // sends one word; valid stays high afterward so back-to-back words need no dip
    task automatic send_word(input tt_pkg::tt_item_t w);
        int                 gap;
        tt_pkg::tt_result_t owed;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= w.mode;
        s_lookup_key   <= w.key;
        s_ply          <= w.ply;
        s_search_depth <= w.depth;
        s_score_in     <= w.score;
        s_move_word    <= w.move;
        s_bound_kind   <= w.bound;
        do @(posedge aclk); while (s_ready !== 1'b1);
        owed = predict_table_access(w);
        pending_results = {pending_results, owed};
        if (w.mode == tt_pkg::MODE_PROBE) begin
            n_probes++;
            n_hits += owed.hit;
        end else begin
            n_stores++;
            n_writes += owed.stored;
        end
    endtask

    // drops valid and holds off until every owed result has been taken
    task automatic settle_queue();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // only called while the table is idle
    task automatic write_generation(input logic [7:0] generation);
        cfg_valid             <= 1'b1;
        cfg_search_generation <= generation;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid         <= 1'b0;
        shadow_generation  = generation;
        n_settings++;
    endtask

    // extremes of key, ply, depth, score and bound, plus the mate threshold on both sides
    task automatic test_boundary_words();
        logic [63:0] key_top;
        logic [63:0] key_zero;
        logic [63:0] key_alias;
        key_top   = 64'hFFFF_FFFF_FFFF_FFFF;
        key_zero  = 64'h0;
        key_alias = 64'h8000_0000_0000_0FFF;
        write_generation(8'd0);
        // empty table misses
        send_word(make_word(tt_pkg::MODE_PROBE, key_zero, 8'd0, 8'd0, 0, 16'h0, 2'd0));
        // mate score pushed out by the full ply
        send_word(make_word(tt_pkg::MODE_STORE, key_top, 8'd255, 8'd255, SCORE_SPAN,
                            16'hFFFF, 2'd2));
        send_word(make_word(tt_pkg::MODE_PROBE, key_top, 8'd0, 8'd0, 0, 16'h0, 2'd0));
        send_word(make_word(tt_pkg::MODE_PROBE, key_top, 8'd255, 8'd0, 0, 16'h0, 2'd0));
        // same slot, different tag
        send_word(make_word(tt_pkg::MODE_PROBE, key_alias, 8'd0, 8'd0, 0, 16'h0, 2'd0));
        // shallower store refused, equal depth replaces
        send_word(make_word(tt_pkg::MODE_STORE, key_alias, 8'd3, 8'd254, 100, 16'h1234, 2'd1));
        send_word(make_word(tt_pkg::MODE_STORE, key_alias, 8'd100, 8'd255, -SCORE_SPAN,
                            16'h0, 2'd3));
        send_word(make_word(tt_pkg::MODE_PROBE, key_top, 8'd0, 8'd0, 0, 16'h0, 2'd0));
        // bound kind three comes back as given
        send_word(make_word(tt_pkg::MODE_PROBE, key_alias, 8'd100, 8'd0, 0, 16'h0, 2'd0));
        send_word(make_word(tt_pkg::MODE_STORE, key_zero, 8'd0, 8'd0, 0, 16'h0, 2'd0));
        send_word(make_word(tt_pkg::MODE_PROBE, key_zero, 8'd255, 8'd0, 0, 16'h0, 2'd0));
        // right at the threshold: untouched both ways
        send_word(make_word(tt_pkg::MODE_STORE, key_zero, 8'd200, 8'd0, MATE_EDGE,
                            16'h00FF, 2'd0));
        send_word(make_word(tt_pkg::MODE_PROBE, key_zero, 8'd200, 8'd0, 0, 16'h0, 2'd0));
        // one past the threshold: adjusted
        send_word(make_word(tt_pkg::MODE_STORE, key_zero, 8'd1, 8'd0, MATE_EDGE + 1,
                            16'hFF00, 2'd2));
        send_word(make_word(tt_pkg::MODE_PROBE, key_zero, 8'd0, 8'd0, 0, 16'h0, 2'd0));
        send_word(make_word(tt_pkg::MODE_STORE, key_zero, 8'd9, 8'd0, -MATE_EDGE,
                            16'h5A5A, 2'd1));
        send_word(make_word(tt_pkg::MODE_PROBE, key_zero, 8'd9, 8'd0, 0, 16'h0, 2'd0));
        send_word(make_word(tt_pkg::MODE_STORE, key_zero, 8'd255, 8'd0, -MATE_EDGE - 1,
                            16'hA5A5, 2'd0));
        send_word(make_word(tt_pkg::MODE_PROBE, key_zero, 8'd3, 8'd0, 0, 16'h0, 2'd0));
    endtask

    // a deeper entry blocks a shallow store until the generation moves on
    task automatic test_generation_replacement();
        logic [63:0] key_deep;
        logic [63:0] key_rival;
        key_deep  = 64'h0123_4567_89AB_C5A5;
        key_rival = 64'hFEDC_BA98_7654_35A5;
        settle_queue();
        write_generation(8'd255);
        send_word(make_word(tt_pkg::MODE_STORE, key_deep, 8'd5, 8'd200, 1234, 16'hBEEF, 2'd0));
        send_word(make_word(tt_pkg::MODE_STORE, key_rival, 8'd5, 8'd10, 77, 16'hCAFE, 2'd1));
        send_word(make_word(tt_pkg::MODE_PROBE, key_deep, 8'd5, 8'd0, 0, 16'h0, 2'd0));
        settle_queue();
        write_generation(8'd1);
        send_word(make_word(tt_pkg::MODE_STORE, key_rival, 8'd7, 8'd10, -500, 16'hCAFE, 2'd2));
        send_word(make_word(tt_pkg::MODE_PROBE, key_deep, 8'd0, 8'd0, 0, 16'h0, 2'd0));
        send_word(make_word(tt_pkg::MODE_PROBE, key_rival, 8'd0, 8'd0, 0, 16'h0, 2'd0));
    endtask

    // random probe/store mix over several generations, one block without idling
    task automatic test_random_traffic();
        logic [SLOT_BITS-1:0] pool_slot [POOL_SLOTS];
        logic [7:0]           plan      [RANDOM_BLOCKS];
        int                   blk;
        int                   n;
        pool_slot[0] = '0;
        pool_slot[1] = '1;
        for (n = 2; n < POOL_SLOTS; n++) begin
            pool_slot[n] = SLOT_BITS'($urandom);
        end
        for (n = 0; n < POOL_SIZE; n++) begin
            key_pool[n] = {$urandom, $urandom};
            key_pool[n][SLOT_BITS-1:0] = pool_slot[n % POOL_SLOTS];
        end
        plan[0] = 8'd255;
        plan[1] = 8'($urandom);
        plan[2] = 8'd0;
        plan[3] = 8'($urandom);
        for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            settle_queue();
            write_generation(plan[blk]);
            no_idle = (blk == 2);
            for (n = 0; n < BLOCK_WORDS; n++) begin
                // sender holds off mid-stream until the block has drained
                if (blk == 1 && n == BLOCK_WORDS / 2) begin
                    settle_queue();
                end
                send_word(random_word());
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random backpressure ahead of every word
    initial begin : result_sink
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready));
        end
    end

    // compare each result word with the oldest owed one
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing owed");
                failures++;
            end else begin
                expected_word = pending_results.pop_front();
                check_field("hit", expected_word.hit, m_hit);
                check_field("hit_depth", expected_word.depth, m_hit_depth);
                check_field("hit_score", expected_word.score, m_hit_score);
                check_field("hit_move", expected_word.move, m_hit_move);
                check_field("hit_bound", expected_word.bound, m_hit_bound);
                check_field("stored", expected_word.stored, m_stored);
            end
        end
    end

    // watchdog: any handshake on any channel counts as progress
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_table[i] = '0;
        end
        shadow_generation = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_boundary_words();
        test_generation_replacement();
        test_random_traffic();

        // wait out everything still owed, then let the pipe run quiet
        settle_queue();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d probes (%0d hits) and %0d stores (%0d replaced)",
                 n_probes, n_hits, n_stores, n_writes);
        $display("over %0d generation writes including both extremes", n_settings);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== transposition_table_top.f =====
src/tt_pkg.sv
src/tt_front.sv
src/tt_queue.sv
src/tt_back.sv
src/transposition_table_top.sv
src/tt_checker.sv
tb/transposition_table_top_tb.sv
